/* rtl/core/rss_pkg.sv */
// Shared types, codes and constant tables for the range scan ring store.
// No dependencies; imported by rss_angle_div, rss_store and range_scan_ring_store.
package rss_pkg;

  localparam int LEN_W = 12;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_OLDEST = 3'd1;
  localparam logic [2:0] OP_NEWEST = 3'd2;
  localparam logic [2:0] OP_SLOT   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_ANGLE  = 3'd2;
  localparam logic [2:0] ST_SLOT   = 3'd3;
  localparam logic [2:0] ST_SAMPLE = 3'd4;

  localparam logic [11:0] ANGLE_MAX = 12'd1800;
  localparam logic [3:0]  RES_RESET = 4'd10;
  localparam int          RECIP_SHIFT = 18;

  typedef struct packed {
    logic samp_we;
    logic samp_re;
    logic len_we;
    logic len_re;
  } mem_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_IDX  = 4'b0100,
    S_RD   = 4'b1000
  } state_t;

  // resolution saturated to 1..10
  function automatic logic [3:0] eff_res(input logic [3:0] r);
    logic [3:0] v;
    v = r;
    if (r < 4'd1) v = 4'd1;
    if (r > 4'd10) v = 4'd10;
    return v;
  endfunction

  // 1 + 1800 / res
  function automatic logic [LEN_W-1:0] scan_dim(input logic [3:0] r);
    logic [LEN_W-1:0] d;
    case (r)
      4'd1:    d = 12'd1801;
      4'd2:    d = 12'd901;
      4'd3:    d = 12'd601;
      4'd4:    d = 12'd451;
      4'd5:    d = 12'd361;
      4'd6:    d = 12'd301;
      4'd7:    d = 12'd258;
      4'd8:    d = 12'd226;
      4'd9:    d = 12'd201;
      default: d = 12'd181;
    endcase
    return d;
  endfunction

  // ceil(2^18 / (2*res)); exact quotient for numerators below 8192
  function automatic logic [17:0] recip(input logic [3:0] r);
    logic [17:0] m;
    case (r)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd5:    m = 18'd26215;
      4'd6:    m = 18'd21846;
      4'd7:    m = 18'd18725;
      4'd8:    m = 18'd16384;
      4'd9:    m = 18'd14564;
      default: m = 18'd13108;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/rss_angle_div.sv */
// Angle to sample index: round(angle / res) by reciprocal multiply, one register.
// Depends on rss_pkg.
module rss_angle_div (
  input  logic        clk,
  input  logic [11:0] angle,
  input  logic [3:0]  res,
  output logic [11:0] index
);
  import rss_pkg::*;

  logic [12:0] num;
  logic [30:0] prod_r;

  assign num = {angle, 1'b0} + 13'(res);

  always_ff @(posedge clk) begin
    prod_r <= num * recip(res);
  end

  assign index = prod_r[RECIP_SHIFT+11:RECIP_SHIFT];

endmodule

/* rtl/core/rss_store.sv */
// Sample memory and per-slot length memory, registered reads.
// Depends on rss_pkg.
module rss_store #(
  parameter int SLOTS     = 16,
  parameter int IW        = 11,
  parameter int DIST_BITS = 16
) (
  input  logic                               clk,
  input  rss_pkg::mem_ctl_t                  ctl,
  input  logic [$clog2(SLOTS)+IW-1:0]        samp_addr,
  input  logic [DIST_BITS-1:0]               samp_wdata,
  output logic [DIST_BITS-1:0]               samp_rdata,
  input  logic [$clog2(SLOTS)-1:0]           len_addr,
  input  logic [rss_pkg::LEN_W-1:0]          len_wdata,
  output logic [rss_pkg::LEN_W-1:0]          len_rdata
);
  import rss_pkg::*;

  logic [DIST_BITS-1:0] samp_mem [SLOTS*(2**IW)];
  logic [LEN_W-1:0]     len_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.samp_we) samp_mem[samp_addr] <= samp_wdata;
    if (ctl.samp_re) samp_rdata <= samp_mem[samp_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.len_we) len_mem[len_addr] <= len_wdata;
    if (ctl.len_re) len_rdata <= len_mem[len_addr];
  end

endmodule

/* rtl/core/range_scan_ring_store.sv */
// Range scan ring store: whole scans held in a ring of SLOTS slots in one sample
// memory, with a stored length per slot. A push or clear request is accepted,
// then written in a memory write state; a read request goes through accept,
// checks and length read with the angle multiply, sample read, and result, set by
// the two dependent registered memory reads, or skips the sample read when a check
// fails and no sample read is needed; the result cycle stretches while an earlier
// result still waits for out_tready. Memories need no clearing after reset.
// Depends on rss_pkg, rss_angle_div and rss_store.
module range_scan_ring_store #(
  parameter int SLOTS       = 16,
  parameter int MAX_SAMPLES = 2048,
  parameter int DIST_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // resolution_tenths
  input  logic        in_tvalid,
  output logic        in_tready,
  // distance_in[15:0], sample_position[26:16], release_req[27],
  // angle_tenths[39:28], slot_number[43:40]
  input  logic [47:0] in_tdata,
  input  logic        in_tlast,      // last_sample
  input  logic [2:0]  in_tuser,      // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata      // distance_out[15:0], status[18:16]
);
  import rss_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(MAX_SAMPLES);
  localparam logic [9:0] SLOTS_V = 10'(SLOTS);

  state_t          state_r;
  logic [3:0]      res_r;
  logic [SW-1:0]   oldest_r, origin_r, rd_slot_r;
  logic [CW-1:0]   count_r;
  logic [LEN_W-1:0] fill_r;
  logic [2:0]      op_r, status_r;
  logic [15:0]     din_r;
  logic            last_r, rel_r, hit_r;
  logic [10:0]     pos_r;
  logic [11:0]     ang_r;
  logic [3:0]      slotno_r;
  logic            out_valid_r;
  logic [15:0]     out_dist_r;
  logic [2:0]      out_status_r;

  logic [3:0]      eres;
  logic [LEN_W-1:0] dim;
  logic [9:0]      wsum, nsum, psum, rsum;
  logic [SW-1:0]   wslot, newest, phys3, oldest_inc;
  logic [11:0]     div_idx, idx;
  logic [LEN_W-1:0] fill_inc;
  logic            fill_ok;

  mem_ctl_t             ctl;
  logic [SW+IW-1:0]     samp_addr;
  logic [DIST_BITS-1:0] samp_wdata, samp_rdata;
  logic [SW-1:0]        len_addr;
  logic [LEN_W-1:0]     len_rdata;
  logic [31:0]          din_ext, q_ext;

  assign eres = eff_res(res_r);
  always_comb begin
    dim = scan_dim(eres);
    if (13'(dim) > 13'(MAX_SAMPLES)) dim = LEN_W'(MAX_SAMPLES);
  end

  always_comb begin
    wsum = 10'(oldest_r) + 10'(count_r);
    if (wsum >= SLOTS_V) wsum = wsum - SLOTS_V;
    nsum = 10'(oldest_r) + 10'(count_r) - 10'd1;
    if (nsum >= SLOTS_V) nsum = nsum - SLOTS_V;
    psum = 10'(origin_r) + 10'(slotno_r);
    if (psum >= SLOTS_V) psum = psum - SLOTS_V;
    rsum = 10'(oldest_r) + 10'd1;
    if (rsum >= SLOTS_V) rsum = rsum - SLOTS_V;
  end
  assign wslot      = wsum[SW-1:0];
  assign newest     = nsum[SW-1:0];
  assign phys3      = psum[SW-1:0];
  assign oldest_inc = rsum[SW-1:0];

  assign fill_ok  = fill_r < dim;
  assign fill_inc = fill_ok ? fill_r + 1'b1 : fill_r;
  assign idx      = (op_r == OP_OLDEST) ? {1'b0, pos_r} : div_idx;

  assign din_ext    = 32'(din_r);
  assign samp_wdata = din_ext[DIST_BITS-1:0];
  assign q_ext      = 32'(samp_rdata);

  rss_angle_div u_div (
    .clk   (clk),
    .angle (ang_r),
    .res   (eres),
    .index (div_idx)
  );

  rss_store #(.SLOTS(SLOTS), .IW(IW), .DIST_BITS(DIST_BITS)) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .samp_addr  (samp_addr),
    .samp_wdata (samp_wdata),
    .samp_rdata (samp_rdata),
    .len_addr   (len_addr),
    .len_wdata  (fill_inc),
    .len_rdata  (len_rdata)
  );

  // slot to read, chosen in the check cycle
  logic [SW-1:0] sel_slot;
  always_comb begin
    case (op_r)
      OP_OLDEST: sel_slot = oldest_r;
      OP_NEWEST: sel_slot = newest;
      default:   sel_slot = phys3;
    endcase
  end

  always_comb begin
    ctl       = '0;
    samp_addr = {rd_slot_r, idx[IW-1:0]};
    len_addr  = sel_slot;
    if (state_r == S_CALC) begin
      if (op_r == OP_PUSH) begin
        samp_addr   = {wslot, fill_r[IW-1:0]};
        len_addr    = wslot;
        ctl.samp_we = fill_ok;
        ctl.len_we  = last_r;
      end else begin
        ctl.len_re = 1'b1;
      end
    end
    if (state_r == S_IDX) ctl.samp_re = 1'b1;
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= RES_RESET;
      oldest_r    <= '0;
      origin_r    <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) res_r <= cfg_wr_data;
      // the result cycle reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_RD) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r     <= in_tuser;
            din_r    <= in_tdata[15:0];
            pos_r    <= in_tdata[26:16];
            rel_r    <= in_tdata[27];
            ang_r    <= in_tdata[39:28];
            slotno_r <= in_tdata[43:40];
            last_r   <= in_tlast;
            state_r  <= S_CALC;
          end
        end
        S_CALC: begin
          status_r  <= ST_OK;
          hit_r     <= 1'b0;
          rd_slot_r <= sel_slot;
          state_r   <= S_IDLE;
          case (op_r)
            OP_PUSH: begin
              if (last_r) begin
                fill_r <= '0;
                if (count_r != CW'(SLOTS)) begin
                  count_r <= count_r + 1'b1;
                  if (count_r + 1'b1 != CW'(SLOTS)) origin_r <= oldest_r;
                end else begin
                  oldest_r <= oldest_inc;
                end
              end else begin
                fill_r <= fill_inc;
              end
            end
            OP_OLDEST: begin
              state_r <= S_IDX;
              if (count_r == '0) begin
                status_r <= ST_EMPTY;
                state_r  <= S_RD;
              end else if ({1'b0, pos_r} >= dim) begin
                status_r <= ST_SAMPLE;
                state_r  <= S_RD;
              end
            end
            OP_NEWEST: begin
              state_r <= S_IDX;
              if (ang_r > ANGLE_MAX) begin
                status_r <= ST_ANGLE;
                state_r  <= S_RD;
              end else if (count_r == '0) begin
                status_r <= ST_EMPTY;
                state_r  <= S_RD;
              end
            end
            OP_SLOT: begin
              state_r <= S_IDX;
              if (ang_r > ANGLE_MAX) begin
                status_r <= ST_ANGLE;
                state_r  <= S_RD;
              end else if ({5'b0, slotno_r} >= 9'(SLOTS)) begin
                status_r <= ST_SLOT;
                state_r  <= S_RD;
              end
            end
            OP_CLEAR: begin
              count_r  <= '0;
              oldest_r <= origin_r;
              fill_r   <= '0;
            end
            default: ;
          endcase
        end
        S_IDX: begin
          hit_r   <= (idx < len_rdata) && (13'(idx) < 13'(MAX_SAMPLES));
          state_r <= S_RD;
          if (op_r == OP_OLDEST && rel_r) begin
            oldest_r <= oldest_inc;
            count_r  <= count_r - 1'b1;
            origin_r <= oldest_inc;   // count falls below full, origin follows
          end
        end
        S_RD: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_dist_r   <= hit_r ? q_ext[15:0] : 16'd0;
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_status_r, out_dist_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("scan count above ring size");
  a_origin_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != CW'(SLOTS)) |-> (origin_r == oldest_r))
    else $error("origin not following oldest on a ring that is not full");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    13'(fill_r) <= 13'(MAX_SAMPLES))
    else $error("fill position past slot size");
  a_read_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && hit_r) |-> (status_r == ST_OK))
    else $error("sample hit on an error request");
`endif

endmodule
